// ===== hw/rtl/isud_pkg.sv =====
// Shared constants, codes and types for the interval set union/difference core.
package isud_pkg;

  localparam int FIELD_W = 16;
  localparam int MAX_RANGES_DEF = 16;
  localparam int INDEX_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OWN_FULL  = 2'd1,
    ST_PART_FULL = 2'd2,
    ST_BAD_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_MV_RD,
    S_MV_WR,
    S_WR_NEW,
    S_Q_RD,
    S_Q_LD,
    S_Q_COV,
    S_Q_STP,
    S_Q_EMIT,
    S_FIN
  } state_t;

endpackage

// ===== hw/rtl/isud_in_if.sv =====
// Request channel: operation word with its range.
interface isud_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      operation;
  logic [isud_pkg::FIELD_W-1:0]    range_low;
  logic [isud_pkg::FIELD_W-1:0]    range_high;

  modport source (output valid, operation, range_low, range_high, input ready);
  modport sink   (input valid, operation, range_low, range_high, output ready);
endinterface

// ===== hw/rtl/isud_out_if.sv =====
// Result channel: one missing range or an empty marker with status.
interface isud_out_if;
  logic                            valid;
  logic                            ready;
  logic [isud_pkg::FIELD_W-1:0]    missing_low;
  logic [isud_pkg::FIELD_W-1:0]    missing_high;
  logic                            empty_result;
  logic                            last_of_run;
  logic [1:0]                      status;

  modport source (output valid, missing_low, missing_high, empty_result, last_of_run, status,
                  input ready);
  modport sink   (input valid, missing_low, missing_high, empty_result, last_of_run, status,
                  output ready);
endinterface

// ===== hw/rtl/interval_set_union_difference_core.sv =====
// Top level: sorted own range set with union (add) and difference (query) against partner list.
//
//   channel | dir | payload
//   req     | in  | operation, range_low, range_high
//   rsp     | out | missing_low, missing_high, empty_result, last_of_run, status
//
// One word at a time: req.ready is high only while idle.
// Load/clear/bad range: straight to the answer. Add: scan the own list, then shift each entry
// to be moved (a read step, then a write step), then write the range and answer; a full set
// answers straight after the scan. Query: read and load each own range, then for each cover
// pass and for the stop pass one partner-memory pass, plus an emit step for each piece;
// every piece leaves through one output register.
// Reset empties both lists; memory contents are not cleared. A stalled rsp holds the sequencer.
module interval_set_union_difference_core #(
  parameter int MAX_RANGES = isud_pkg::MAX_RANGES_DEF,
  parameter int INDEX_BITS = isud_pkg::INDEX_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  isud_in_if.sink    req,
  isud_out_if.source rsp
);

  localparam int IW = INDEX_BITS;
  localparam int AW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int DW = 2 * IW;
  localparam int FW = isud_pkg::FIELD_W;

  isud_pkg::state_t state, state_next;

  logic [DW-1:0] own_mem  [MAX_RANGES];
  logic [DW-1:0] part_mem [MAX_RANGES];
  logic [DW-1:0] o_rdata, p_rdata;
  logic [AW-1:0] o_raddr, o_waddr, p_raddr, p_waddr;
  logic          o_we, p_we;
  logic [DW-1:0] o_wdata, p_wdata;

  logic [CW-1:0] ocount, pcount;
  logic [CW-1:0] j_rd, scan_limit, f_cnt, m_cnt, src, mv_left, qi;
  logic          rd_pend, scan_state, issue, scan_done;
  logic [IW-1:0] a_lo, a_hi, end_r, stop, pend_lo, pend_hi;
  logic [IW:0]   cur;
  logic          covered, pend_valid, res_query;
  isud_pkg::status_t res_status;

  logic          accept, out_free, in_bad;
  logic [IW-1:0] in_lo, in_hi;
  logic [IW-1:0] rlo, rhi, plo, phi;
  logic [CW:0]   new_count;
  logic          add_fail;

  assign in_lo  = IW'(req.range_low);
  assign in_hi  = IW'(req.range_high);
  assign in_bad = in_lo > in_hi;
  assign accept = req.valid && req.ready;
  assign req.ready = (state == isud_pkg::S_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;

  assign rlo = o_rdata[DW-1:IW];
  assign rhi = o_rdata[IW-1:0];
  assign plo = p_rdata[DW-1:IW];
  assign phi = p_rdata[IW-1:0];

  assign scan_state = (state == isud_pkg::S_ADD_SCAN) || (state == isud_pkg::S_Q_COV) ||
                      (state == isud_pkg::S_Q_STP);
  assign scan_limit = (state == isud_pkg::S_ADD_SCAN) ? ocount : pcount;
  assign issue      = scan_state && (j_rd != scan_limit);
  assign scan_done  = scan_state && (j_rd == scan_limit) && !rd_pend;
  assign new_count  = {1'b0, ocount} - {1'b0, m_cnt} + (CW+1)'(1);
  assign add_fail   = new_count > (CW+1)'(MAX_RANGES);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      isud_pkg::S_IDLE: begin
        if (accept) begin
          if (req.operation == isud_pkg::OP_ADD && !in_bad) state_next = isud_pkg::S_ADD_SCAN;
          else if (req.operation == isud_pkg::OP_QUERY) state_next = isud_pkg::S_Q_RD;
          else state_next = isud_pkg::S_FIN;
        end
      end
      isud_pkg::S_ADD_SCAN: begin
        if (scan_done) state_next = add_fail ? isud_pkg::S_FIN : isud_pkg::S_MV_RD;
      end
      isud_pkg::S_MV_RD: state_next = (mv_left != '0) ? isud_pkg::S_MV_WR : isud_pkg::S_WR_NEW;
      isud_pkg::S_MV_WR: state_next = isud_pkg::S_MV_RD;
      isud_pkg::S_WR_NEW: state_next = isud_pkg::S_FIN;
      isud_pkg::S_Q_RD: state_next = (qi == ocount) ? isud_pkg::S_FIN : isud_pkg::S_Q_LD;
      isud_pkg::S_Q_LD: state_next = isud_pkg::S_Q_COV;
      isud_pkg::S_Q_COV: begin
        if (scan_done) begin
          if (cur > {1'b0, end_r}) state_next = isud_pkg::S_Q_RD;
          else if (!covered) state_next = isud_pkg::S_Q_STP;
        end
      end
      isud_pkg::S_Q_STP: if (scan_done) state_next = isud_pkg::S_Q_EMIT;
      isud_pkg::S_Q_EMIT: begin
        if (out_free) state_next = (stop < end_r) ? isud_pkg::S_Q_COV : isud_pkg::S_Q_RD;
      end
      isud_pkg::S_FIN: if (out_free) state_next = isud_pkg::S_IDLE;
      default: state_next = isud_pkg::S_IDLE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    o_raddr = j_rd[AW-1:0];
    p_raddr = j_rd[AW-1:0];
    o_we    = 1'b0;
    o_waddr = src[AW-1:0];
    o_wdata = o_rdata;
    p_we    = 1'b0;
    p_waddr = pcount[AW-1:0];
    p_wdata = {in_lo, in_hi};
    unique case (state)
      isud_pkg::S_IDLE: begin
        p_we = accept && (req.operation == isud_pkg::OP_LOAD) && !in_bad &&
               (pcount != CW'(MAX_RANGES));
      end
      isud_pkg::S_MV_RD: o_raddr = src[AW-1:0];
      isud_pkg::S_MV_WR: begin
        o_we    = 1'b1;
        o_waddr = (m_cnt == '0) ? AW'(src + CW'(1)) : AW'(src - m_cnt + CW'(1));
      end
      isud_pkg::S_WR_NEW: begin
        o_we    = 1'b1;
        o_waddr = f_cnt[AW-1:0];
        o_wdata = {a_lo, a_hi};
      end
      isud_pkg::S_Q_RD: o_raddr = qi[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (o_we) own_mem[o_waddr] <= o_wdata;
    o_rdata <= own_mem[o_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) part_mem[p_waddr] <= p_wdata;
    p_rdata <= part_mem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= isud_pkg::S_IDLE;
      ocount     <= '0;
      pcount     <= '0;
      rd_pend    <= 1'b0;
      j_rd       <= '0;
      pend_valid <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp.ready) rsp.valid <= 1'b0;
      j_rd    <= j_rd + CW'(issue);
      rd_pend <= issue;

      unique case (state)
        isud_pkg::S_IDLE: begin
          res_status <= isud_pkg::ST_OK;
          res_query  <= 1'b0;
          if (accept) begin
            unique case (req.operation)
              isud_pkg::OP_ADD: begin
                if (in_bad) res_status <= isud_pkg::ST_BAD_RANGE;
                a_lo  <= in_lo;
                a_hi  <= in_hi;
                f_cnt <= '0;
                m_cnt <= '0;
                j_rd  <= '0;
              end
              isud_pkg::OP_LOAD: begin
                if (in_bad) res_status <= isud_pkg::ST_BAD_RANGE;
                else if (pcount == CW'(MAX_RANGES)) res_status <= isud_pkg::ST_PART_FULL;
                else pcount <= pcount + CW'(1);
              end
              isud_pkg::OP_QUERY: begin
                res_query  <= 1'b1;
                qi         <= '0;
                pend_valid <= 1'b0;
              end
              isud_pkg::OP_CLEAR: begin
                ocount <= '0;
                pcount <= '0;
              end
              default: ;
            endcase
          end
        end
        isud_pkg::S_ADD_SCAN: begin
          if (rd_pend) begin
            if ({1'b0, rhi} + (IW+1)'(1) < {1'b0, a_lo}) begin
              f_cnt <= f_cnt + CW'(1);
            end else if (!({1'b0, rlo} > {1'b0, a_hi} + (IW+1)'(1))) begin
              m_cnt <= m_cnt + CW'(1);
              if (rlo < a_lo) a_lo <= rlo;
              if (rhi > a_hi) a_hi <= rhi;
            end
          end
          if (scan_done) begin
            if (add_fail) res_status <= isud_pkg::ST_OWN_FULL;
            mv_left <= ocount - f_cnt - m_cnt;
            src     <= (m_cnt == '0) ? ocount - CW'(1) : f_cnt + m_cnt;
          end
        end
        isud_pkg::S_MV_WR: begin
          // shift right runs downwards, shift left upwards
          src     <= (m_cnt == '0) ? src - CW'(1) : src + CW'(1);
          mv_left <= mv_left - CW'(1);
        end
        isud_pkg::S_WR_NEW: ocount <= CW'(new_count);
        isud_pkg::S_Q_LD: begin
          cur     <= {1'b0, rlo};
          end_r   <= rhi;
          qi      <= qi + CW'(1);
          covered <= 1'b0;
          j_rd    <= '0;
          rd_pend <= 1'b0;
        end
        isud_pkg::S_Q_COV: begin
          if (rd_pend && ({1'b0, plo} <= cur) && (cur <= {1'b0, phi})) begin
            cur     <= {1'b0, phi} + (IW+1)'(1);
            covered <= 1'b1;
          end
          if (scan_done) begin
            covered <= 1'b0;
            j_rd    <= '0;
            stop    <= end_r;
          end
        end
        isud_pkg::S_Q_STP: begin
          if (rd_pend && ({1'b0, plo} > cur) && (plo <= stop)) stop <= plo - IW'(1);
        end
        isud_pkg::S_Q_EMIT: begin
          if (out_free) begin
            if (pend_valid) begin
              rsp.valid        <= 1'b1;
              rsp.missing_low  <= FW'(pend_lo);
              rsp.missing_high <= FW'(pend_hi);
              rsp.empty_result <= 1'b0;
              rsp.last_of_run  <= 1'b0;
              rsp.status       <= isud_pkg::ST_OK;
            end
            pend_valid <= 1'b1;
            pend_lo    <= IW'(cur);
            pend_hi    <= stop;
            cur        <= {1'b0, stop} + (IW+1)'(1);
            covered    <= 1'b0;
            j_rd       <= '0;
          end
        end
        isud_pkg::S_FIN: begin
          if (out_free) begin
            rsp.valid       <= 1'b1;
            rsp.last_of_run <= 1'b1;
            rsp.status      <= res_status;
            if (res_query && pend_valid) begin
              rsp.missing_low  <= FW'(pend_lo);
              rsp.missing_high <= FW'(pend_hi);
              rsp.empty_result <= 1'b0;
            end else begin
              rsp.missing_low  <= '0;
              rsp.missing_high <= '0;
              rsp.empty_result <= 1'b1;
            end
            if (res_query) pcount <= '0;
            pend_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
